// ----- design/pskl_pkg.sv -----
// Shared constants, types and helper functions for the partitioned sorted key lookup.
package pskl_pkg;

  // Store geometry.
  localparam int MAX_ENTRIES = 4096;
  localparam int NUM_TYPES   = 7;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths.
  localparam int OP_W   = 2;
  localparam int TYPE_W = 3;
  localparam int KEY_W  = 64;
  localparam int OFF_W  = 48;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [TYPE_W-1:0] ptype_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Operation codes.
  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_HOLD
  } state_t;

  // Commands from the sequencer to the count registers.
  typedef struct packed {
    logic   load;
    logic   clear;
    ptype_t ptype;
  } cnt_cmd_t;

  // Count information for the addressed type.
  typedef struct packed {
    logic type_ok;
    cnt_t count;
    cnt_t base;
    cnt_t total;
  } cnt_info_t;

  // Finished lookup handed to the output register.
  typedef struct packed {
    logic load;
    logic found;
    off_t offset;
  } res_t;

  // Midpoint of the inclusive range [lo, hi - 1], rounded down; requires lo < hi.
  function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi);
    cnt_t span;
    span = hi - lo - cnt_t'(1);
    return lo + (span >> 1);
  endfunction

endpackage

// ----- design/pskl_entry_mem.sv -----
// Entry store: synchronous memory of keys and offsets, one write and one read port.
module pskl_entry_mem (
  input  logic           clk,
  input  logic           we,
  input  pskl_pkg::addr_t waddr,
  input  pskl_pkg::key_t  wkey,
  input  pskl_pkg::off_t  woff,
  input  logic           re,
  input  pskl_pkg::addr_t raddr,
  output pskl_pkg::key_t  rkey,
  output pskl_pkg::off_t  roff
);
  import pskl_pkg::*;

  key_t key_mem [MAX_ENTRIES];
  off_t off_mem [MAX_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      off_mem[waddr] <= woff;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rkey <= key_mem[raddr];
      roff <= off_mem[raddr];
    end
  end

endmodule

// ----- design/pskl_counts.sv -----
// Per-type entry counts with running region bases and the store fill total.
module pskl_counts (
  input  logic                clk,
  input  logic                rst,
  input  pskl_pkg::cnt_cmd_t  cmd,
  input  pskl_pkg::ptype_t    sel_type,
  output pskl_pkg::cnt_info_t info
);
  import pskl_pkg::*;

  // bases[t] is the sum of the counts of all types below t; bases[NUM_TYPES] is the total.
  cnt_t counts [NUM_TYPES];
  cnt_t bases  [NUM_TYPES+1];

  // A load bumps its own count and the base of every higher type.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        counts[t] <= '0;
      end
      for (int u = 0; u <= NUM_TYPES; u++) begin
        bases[u] <= '0;
      end
    end else if (cmd.load) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        if (cmd.ptype == TYPE_W'(t)) begin
          counts[t] <= counts[t] + cnt_t'(1);
        end
      end
      for (int u = 0; u <= NUM_TYPES; u++) begin
        if (TYPE_W'(u) > cmd.ptype || u >= (1 << TYPE_W)) begin
          bases[u] <= bases[u] + cnt_t'(1);
        end
      end
    end
  end

  // Select the count and base of the addressed type.
  always_comb begin
    info.type_ok = 1'b0;
    info.count   = '0;
    info.base    = '0;
    info.total   = bases[NUM_TYPES];
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (sel_type == TYPE_W'(t)) begin
        info.type_ok = 1'b1;
        info.count   = counts[t];
        info.base    = bases[t];
      end
    end
  end

endmodule

// ----- design/pskl_search.sv -----
// Command sequencer: loads, clears and the binary search over one type region.
module pskl_search (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pskl_pkg::op_t       opcode,
  input  pskl_pkg::key_t      search_key,
  input  pskl_pkg::cnt_info_t info,
  output pskl_pkg::cnt_cmd_t  cnt_cmd,
  input  pskl_pkg::ptype_t    particle_type,
  output logic                mem_we,
  output pskl_pkg::addr_t     mem_waddr,
  output logic                mem_re,
  output pskl_pkg::addr_t     mem_raddr,
  input  pskl_pkg::key_t      rd_key,
  input  pskl_pkg::off_t      rd_off,
  input  logic                res_free,
  output pskl_pkg::res_t      res
);
  import pskl_pkg::*;

  state_t state, state_next;
  cnt_t   lo, lo_next;
  cnt_t   hi, hi_next;
  cnt_t   base, base_next;
  cnt_t   mid, mid_next;
  key_t   want, want_next;
  logic   hit, hit_next;
  off_t   hit_off, hit_off_next;

  cnt_t   probe_mid;
  cnt_t   probe_addr;
  logic   key_lt;
  logic   key_gt;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    lo      <= lo_next;
    hi      <= hi_next;
    base    <= base_next;
    mid     <= mid_next;
    want    <= want_next;
    hit     <= hit_next;
    hit_off <= hit_off_next;
  end

  // Signed comparison of the probed key against the wanted one.
  assign key_lt = $signed(rd_key) < $signed(want);
  assign key_gt = $signed(rd_key) > $signed(want);

  // Next state, probe address and control outputs.
  always_comb begin
    state_next   = state;
    lo_next      = lo;
    hi_next      = hi;
    base_next    = base;
    mid_next     = mid;
    want_next    = want;
    hit_next     = hit;
    hit_off_next = hit_off;
    in_ready     = 1'b0;
    cnt_cmd      = '{load: 1'b0, clear: 1'b0, ptype: particle_type};
    mem_we       = 1'b0;
    mem_waddr    = info.total[ADDR_W-1:0];
    mem_re       = 1'b0;
    probe_mid    = '0;
    probe_addr   = '0;
    res          = '{load: 1'b0, found: hit, offset: hit_off};

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_LOAD: begin
              if (info.type_ok && int'(info.total) < MAX_ENTRIES) begin
                mem_we       = 1'b1;
                cnt_cmd.load = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_cmd.clear = 1'b1;
            end
            OP_LOOKUP: begin
              lo_next      = '0;
              hi_next      = info.count;
              base_next    = info.base;
              want_next    = search_key;
              hit_next     = 1'b0;
              hit_off_next = '0;
              probe_mid    = mid_of('0, info.count);
              probe_addr   = info.base + probe_mid;
              mid_next     = probe_mid;
              if (info.type_ok && info.count != '0 && int'(probe_addr) < MAX_ENTRIES) begin
                mem_re     = 1'b1;
                state_next = ST_PROBE;
              end else begin
                state_next = ST_HOLD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PROBE: begin
        // Narrow the range on the word read for the current midpoint.
        if (key_lt) begin
          lo_next = mid + cnt_t'(1);
        end else if (key_gt) begin
          hi_next = mid;
        end
        if (!key_lt && !key_gt) begin
          hit_next     = 1'b1;
          hit_off_next = rd_off;
          state_next   = ST_HOLD;
        end else if (lo_next < hi_next) begin
          probe_mid  = mid_of(lo_next, hi_next);
          probe_addr = base + probe_mid;
          mid_next   = probe_mid;
          if (int'(probe_addr) < MAX_ENTRIES) begin
            mem_re = 1'b1;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          state_next = ST_HOLD;
        end
      end

      ST_HOLD: begin
        // Wait for the output register to take the result.
        if (res_free) begin
          res.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    mem_raddr = probe_addr[ADDR_W-1:0];
  end

endmodule

// ----- design/partitioned_sorted_key_lookup.sv -----
// Top level of the partitioned sorted key lookup: counts, entry store, sequencer, output register.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_ready, opcode, particle_type,     | in
//           | search_key, entry_offset                       |
//   output  | out_valid, out_ready, result_offset, found     | out
//
// A load or clear word is carried out as it is accepted. A lookup issues the first
// memory read as it is accepted, then for each probe compares the word read and issues the next
// read (up to 13 probes for a region of 4096 entries), and at last moves the result into the
// output register.
// Reset clears the type counts and the sequencer; the entry store is not cleared.
// A result waiting in the output register does not stop loads or clears; a
// finished lookup waits for the output register to be free.
module partitioned_sorted_key_lookup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pskl_pkg::OP_W-1:0]   opcode,
  input  logic [pskl_pkg::TYPE_W-1:0] particle_type,
  input  logic [pskl_pkg::KEY_W-1:0]  search_key,
  input  logic [pskl_pkg::OFF_W-1:0]  entry_offset,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pskl_pkg::OFF_W-1:0]  result_offset,
  output logic                      found
);
  import pskl_pkg::*;

  cnt_cmd_t  cnt_cmd;
  cnt_info_t info;
  logic      mem_we;
  addr_t     mem_waddr;
  logic      mem_re;
  addr_t     mem_raddr;
  key_t      rd_key;
  off_t      rd_off;
  logic      res_free;
  res_t      res;

  pskl_counts u_counts (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cnt_cmd),
    .sel_type (particle_type),
    .info     (info)
  );

  pskl_entry_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (search_key),
    .woff  (entry_offset),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rkey  (rd_key),
    .roff  (rd_off)
  );

  pskl_search u_search (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .search_key    (search_key),
    .info          (info),
    .cnt_cmd       (cnt_cmd),
    .particle_type (particle_type),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .rd_key        (rd_key),
    .rd_off        (rd_off),
    .res_free      (res_free),
    .res           (res)
  );

  // The output register is free when empty or being read this cycle.
  assign res_free = !out_valid || out_ready;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res.load) begin
      result_offset <= res.offset;
      found         <= res.found;
    end
  end

endmodule

// ----- tb/sv/partitioned_sorted_key_lookup_tb.sv -----
// Self-checking testbench for the partitioned sorted key lookup: directed and random words.
module partitioned_sorted_key_lookup_tb;
  import pskl_pkg::*;

  localparam int STALL_MAX    = 12;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 40;
  localparam int TARGET_WORDS = 650;
  localparam int REPORT_LIMIT = 10;

  // The spare opcode, which the block ignores.
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct {
    off_t offset;
    logic found;
  } answer_t;

  // Mirror of the entry store and type counts, plus the answers still owed by the block.
  class lookup_checker;
    key_t    entry_keys[MAX_ENTRIES];
    off_t    entry_offsets[MAX_ENTRIES];
    int      type_counts[NUM_TYPES];
    answer_t owed_answers[$];
    int      errors;

    function new();
      errors = 0;
      foreach (type_counts[i]) type_counts[i] = 0;
    endfunction

    function int entries_held();
      int sum;
      sum = 0;
      foreach (type_counts[i]) sum += type_counts[i];
      return sum;
    endfunction

    // Binary search of one type region, midpoint rounded down over an inclusive range.
    function answer_t search_region(ptype_t ptype, key_t key);
      answer_t ans;
      int base;
      int lo;
      int hi;
      int mid;
      int addr;
      ans.offset = '0;
      ans.found  = 1'b0;
      if (ptype >= NUM_TYPES) return ans;
      base = 0;
      for (int t = 0; t < ptype; t++) base += type_counts[t];
      lo = 0;
      hi = type_counts[ptype];
      while (lo < hi) begin
        mid  = lo + (hi - lo - 1) / 2;
        addr = base + mid;
        if (addr >= MAX_ENTRIES) break;
        if ($signed(entry_keys[addr]) < $signed(key)) begin
          lo = mid + 1;
        end else if ($signed(entry_keys[addr]) > $signed(key)) begin
          hi = mid;
        end else begin
          ans.offset = entry_offsets[addr];
          ans.found  = 1'b1;
          break;
        end
      end
      return ans;
    endfunction

    // Updates the mirror for an accepted input word.
    function void note_word(op_t op, ptype_t ptype, key_t key, off_t off);
      int slot;
      case (op)
        OP_LOAD: begin
          slot = entries_held();
          if (ptype < NUM_TYPES && slot < MAX_ENTRIES) begin
            entry_keys[slot]    = key;
            entry_offsets[slot] = off;
            type_counts[ptype]++;
          end
        end
        OP_CLEAR: begin
          foreach (type_counts[i]) type_counts[i] = 0;
        end
        OP_LOOKUP: begin
          owed_answers.push_back(search_region(ptype, key));
        end
        default: begin
        end
      endcase
    endfunction

    // Compares an accepted output word with the oldest owed answer.
    function void check_answer(off_t off, logic fnd);
      answer_t want;
      if (owed_answers.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result word: offset=%h found=%b", off, fnd);
        return;
      end
      want = owed_answers.pop_front();
      if (want.offset !== off || want.found !== fnd) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result mismatch: expected offset=%h found=%b, got offset=%h found=%b",
                   want.offset, want.found, off, fnd);
      end
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  op_t    opcode;
  ptype_t particle_type;
  key_t   search_key;
  off_t   entry_offset;
  logic   out_valid;
  logic   out_ready;
  off_t   result_offset;
  logic   found;

  lookup_checker chk = new();

  int   tx_gap_max;
  int   rx_stall_max;
  bit   hold_off_pending;
  int   words_sent;
  key_t region_keys[NUM_TYPES][$];

  partitioned_sorted_key_lookup dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .particle_type (particle_type),
    .search_key    (search_key),
    .entry_offset  (entry_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_offset (result_offset),
    .found         (found)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic key_t random_key();
    return key_t'({$urandom, $urandom});
  endfunction

  function automatic off_t random_offset();
    return off_t'({$urandom, $urandom});
  endfunction

  // Offers one word after a random gap and waits until the block takes it.
  task automatic send_word(op_t op, ptype_t ptype, key_t key, off_t off);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode        = op;
    particle_type = ptype;
    search_key    = key;
    entry_offset  = off;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.note_word(op, ptype, key, off);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the input back until every owed answer has come out.
  task automatic wait_for_answers();
    in_valid = 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Loads one region with ascending keys; sometimes with repeats or two entries swapped.
  task automatic load_region(int t, int n, bit messy);
    key_t k;
    key_t step;
    key_t tmp;
    int   last;
    region_keys[t].delete();
    k = key_t'($signed({$urandom, $urandom}) >>> 2);
    for (int i = 0; i < n; i++) begin
      region_keys[t].push_back(k);
      if (messy && $urandom_range(0, 7) == 0) step = '0;
      else if ($urandom_range(0, 1) == 1) step = key_t'($urandom_range(1, 3));
      else step = key_t'($urandom) + 1;
      k = k + step;
    end
    if (messy && n >= 2 && $urandom_range(0, 9) == 0) begin
      last = n - 1;
      tmp = region_keys[t][0];
      region_keys[t][0] = region_keys[t][last];
      region_keys[t][last] = tmp;
    end
    foreach (region_keys[t][i]) send_word(OP_LOAD, ptype_t'(t), region_keys[t][i], random_offset());
  endtask

  // Lookups aimed mostly at stored keys and their neighbours.
  task automatic ask_lookups(int n);
    int   t;
    int   pick;
    key_t k;
    repeat (n) begin
      t = ($urandom_range(0, 15) == 0) ? NUM_TYPES : $urandom_range(0, NUM_TYPES - 1);
      pick = $urandom_range(0, 9);
      k = random_key();
      if (t < NUM_TYPES && region_keys[t].size() > 0 && pick < 8) begin
        k = region_keys[t][$urandom_range(0, region_keys[t].size() - 1)];
        if (pick == 6) k = k + 1;
        else if (pick == 7) k = k - 1;
      end
      send_word(OP_LOOKUP, ptype_t'(t), k, random_offset());
    end
  endtask

  // Arbitrary words of any opcode and type.
  task automatic send_noise(int n);
    repeat (n)
      send_word(op_t'($urandom_range(0, 3)), ptype_t'($urandom_range(0, 7)),
                random_key(), random_offset());
  endtask

  // Output side: random stalls per word, plus one long hold-off on request.
  initial begin
    bit took;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_pending) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_pending = 1'b0;
      end
      if (rx_stall_max > 0 && $urandom_range(0, rx_stall_max) > 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, rx_stall_max)) @(negedge clk);
      end
      out_ready = 1'b1;
      took = 1'b0;
      while (!took && !hold_off_pending) begin
        @(posedge clk);
        took = out_valid;
        @(negedge clk);
      end
    end
  end

  // Every output word taken by the receiver is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) chk.check_answer(result_offset, found);
  end

  // Main stimulus.
  initial begin
    int session;
    rst              = 1'b1;
    in_valid         = 1'b0;
    opcode           = OP_LOAD;
    particle_type    = '0;
    search_key       = '0;
    entry_offset     = '0;
    hold_off_pending = 1'b0;
    tx_gap_max       = STALL_MAX;
    rx_stall_max     = STALL_MAX;
    words_sent       = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: empty region, type out of range, spare opcode, key extremes, misses.
    send_word(OP_LOOKUP, ptype_t'(0), '0, '0);
    send_word(OP_LOOKUP, ptype_t'(7), '0, '0);
    send_word(OP_UNUSED, ptype_t'(5), '1, '1);
    send_word(OP_LOAD, ptype_t'(7), key_t'(1), off_t'(1));
    send_word(OP_LOAD, ptype_t'(0), 64'h8000_0000_0000_0000, '0);
    send_word(OP_LOAD, ptype_t'(0), '1, '1);
    send_word(OP_LOAD, ptype_t'(0), '0, 48'h1234_5678_9abc);
    send_word(OP_LOAD, ptype_t'(0), 64'h7fff_ffff_ffff_ffff, 48'h8000_0000_0001);
    send_word(OP_LOAD, ptype_t'(2), key_t'(5), off_t'(55));
    send_word(OP_LOAD, ptype_t'(2), key_t'(10), off_t'(100));
    send_word(OP_LOAD, ptype_t'(6), 64'h5555_5555_5555_5555, 48'haaaa_aaaa_aaaa);
    send_word(OP_LOOKUP, ptype_t'(0), 64'h8000_0000_0000_0000, '0);
    send_word(OP_LOOKUP, ptype_t'(0), '1, '0);
    send_word(OP_LOOKUP, ptype_t'(0), '0, '0);
    send_word(OP_LOOKUP, ptype_t'(0), 64'h7fff_ffff_ffff_ffff, '0);
    send_word(OP_LOOKUP, ptype_t'(0), key_t'(1), '0);
    send_word(OP_LOOKUP, ptype_t'(1), key_t'(5), '0);
    send_word(OP_LOOKUP, ptype_t'(2), key_t'(10), '0);
    send_word(OP_LOOKUP, ptype_t'(2), key_t'(3), '0);
    send_word(OP_LOOKUP, ptype_t'(6), 64'h5555_5555_5555_5555, '0);
    // A load out of type order lands in the next free slot and shifts later regions.
    send_word(OP_LOAD, ptype_t'(1), key_t'(5), off_t'(7));
    send_word(OP_LOOKUP, ptype_t'(1), key_t'(5), '0);
    send_word(OP_LOOKUP, ptype_t'(6), key_t'(5), '0);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_LOOKUP, ptype_t'(0), '0, '0);
    wait_for_answers();

    // Random sessions: mostly a clear, ordered loads and lookups; sometimes pure noise.
    session = 0;
    while (words_sent < TARGET_WORDS) begin
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : STALL_MAX;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : STALL_MAX;
      if (session >= 2 && $urandom_range(0, 6) == 0) begin
        send_noise($urandom_range(5, 20));
      end else begin
        send_word(OP_CLEAR, ptype_t'($urandom_range(0, 7)), random_key(), random_offset());
        for (int t = 0; t < NUM_TYPES; t++)
          load_region(t, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(0, 8), 1'b1);
        // One session lets the output back up so that the input stalls.
        if (session == 1) begin
          tx_gap_max = 0;
          hold_off_pending = 1'b1;
        end
        ask_lookups($urandom_range(5, 25));
        if ($urandom_range(0, 3) == 0) send_noise(2);
      end
      if (session % 5 == 4) wait_for_answers();
      session++;
    end

    wait_for_answers();
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("[partitioned_sorted_key_lookup] OK");
    end else begin
      $display("[partitioned_sorted_key_lookup] ERROR");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #2000000;
    $display("[partitioned_sorted_key_lookup] ERROR");
    $finish;
  end

endmodule

// ----- partitioned_sorted_key_lookup.f -----
design/pskl_pkg.sv
design/pskl_entry_mem.sv
design/pskl_counts.sv
design/pskl_search.sv
design/partitioned_sorted_key_lookup.sv
tb/sv/partitioned_sorted_key_lookup_tb.sv
